@@ design/b64u_pkg.sv @@
package b64u_pkg;

	// One input item: a raw octet and the end-of-message flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// One result item: a character, the end flag and the empty marker.
	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
		logic       empty_message;
	} out_item_t;

	// Up to two results produced by one input item.
	typedef struct packed {
		out_item_t  first;
		out_item_t  second;
		logic [1:0] count;
	} res_pair_t;

	localparam int unsigned SEXTET_W = 6;
	localparam int unsigned CHAR_W   = 7;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ULINE   = 7'h5F;
	localparam logic [CHAR_W-1:0] CHAR_EMPTY   = 7'h00;

	localparam logic [SEXTET_W-1:0] LAST_UPPER = 6'd25;
	localparam logic [SEXTET_W-1:0] LAST_LOWER = 6'd51;
	localparam logic [SEXTET_W-1:0] LAST_DIGIT = 6'd61;
	localparam logic [SEXTET_W-1:0] SEXTET_MINUS = 6'd62;
	localparam logic [SEXTET_W-1:0] OFS_LOWER = 6'd26;
	localparam logic [SEXTET_W-1:0] OFS_DIGIT = 6'd52;

	// Number of bytes of the current three-byte group already consumed.
	localparam logic [1:0] PHASE_0 = 2'd0;
	localparam logic [1:0] PHASE_1 = 2'd1;
	localparam logic [1:0] PHASE_2 = 2'd2;

	// Maps a six-bit group to its base64url character.
	function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
		logic [CHAR_W-1:0] v7;
		logic [CHAR_W-1:0] ch;
		v7 = {1'b0, v};
		if (v <= LAST_UPPER) begin
			ch = CHAR_UPPER_A + v7;
		end else if (v <= LAST_LOWER) begin
			ch = CHAR_LOWER_A + v7 - {1'b0, OFS_LOWER};
		end else if (v <= LAST_DIGIT) begin
			ch = CHAR_DIGIT_0 + v7 - {1'b0, OFS_DIGIT};
		end else if (v == SEXTET_MINUS) begin
			ch = CHAR_MINUS;
		end else begin
			ch = CHAR_ULINE;
		end
		return ch;
	endfunction

endpackage

@@ design/b64u_core.sv @@
module b64u_core (
	input  logic               clk,
	input  logic               arst_n,
	input  b64u_pkg::in_item_t item_s1,
	input  logic               advance,
	input  logic               trim,
	output b64u_pkg::res_pair_t pair
);
	import b64u_pkg::*;

	logic       still_leading_q;
	logic [1:0] phase_q;
	logic [3:0] carry_q;

	logic       still_leading_d;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic       skip;
	logic [SEXTET_W-1:0] sx0;
	logic [SEXTET_W-1:0] sx1;
	logic [7:0] b;

	// Encode the registered item against the running group state.
	always_comb begin
		b               = item_s1.data_byte;
		skip            = trim && still_leading_q && (b == 8'h00);
		sx0             = '0;
		sx1             = '0;
		still_leading_d = 1'b0;
		phase_d         = phase_q;
		carry_d         = carry_q;
		pair            = '0;

		if (skip) begin
			// A skipped leading zero yields nothing, unless it ends the message.
			still_leading_d     = 1'b1;
			phase_d             = PHASE_0;
			carry_d             = '0;
			pair.first.out_char = CHAR_EMPTY;
			pair.first.last_char     = 1'b1;
			pair.first.empty_message = 1'b1;
			pair.count          = item_s1.final_byte ? 2'd1 : 2'd0;
		end else begin
			case (phase_q)
				PHASE_1: begin
					sx0     = {carry_q[1:0], b[7:4]};
					carry_d = b[3:0];
					phase_d = PHASE_2;
				end
				PHASE_2: begin
					sx0     = {carry_q, b[7:6]};
					sx1     = b[5:0];
					carry_d = '0;
					phase_d = PHASE_0;
				end
				default: begin
					sx0     = b[7:2];
					carry_d = {2'b00, b[1:0]};
					phase_d = PHASE_1;
				end
			endcase

			pair.count = (phase_d == PHASE_0) ? 2'd2 : 2'd1;

			// On the final byte the leftover bits are flushed, zero-filled.
			if (item_s1.final_byte) begin
				if (phase_d == PHASE_1) begin
					sx1        = {carry_d[1:0], 4'b0000};
					pair.count = 2'd2;
				end else if (phase_d == PHASE_2) begin
					sx1        = {carry_d, 2'b00};
					pair.count = 2'd2;
				end
				still_leading_d = 1'b1;
				phase_d         = PHASE_0;
				carry_d         = '0;
			end

			pair.first.out_char       = sextet_char(sx0);
			pair.second.out_char      = sextet_char(sx1);
			pair.first.last_char      = item_s1.final_byte && (pair.count == 2'd1);
			pair.second.last_char     = item_s1.final_byte;
		end
	end

	// Group state moves on when the registered item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_leading_q <= 1'b1;
			phase_q         <= PHASE_0;
			carry_q         <= '0;
		end else if (advance) begin
			still_leading_q <= still_leading_d;
			phase_q         <= phase_d;
			carry_q         <= carry_d;
		end
	end

endmodule

@@ design/b64u_outbuf.sv @@
module b64u_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64u_pkg::res_pair_t  pair,
	input  logic                 load,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output b64u_pkg::out_item_t  out_item
);
	import b64u_pkg::*;

	res_pair_t  pair_q;
	logic [1:0] cnt_q;
	logic       idx_q;
	logic       take;
	logic       last_take;

	// The held pair is sent one item per cycle while out_stall is low, first then second.
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = idx_q ? pair_q.second : pair_q.first;
	assign take      = out_valid && !out_stall;
	assign last_take = take && (idx_q || (cnt_q == 2'd1));
	assign free      = !out_valid || last_take;

	// Count and index of the held pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= 1'b0;
		end else if (load) begin
			cnt_q <= pair.count;
			idx_q <= 1'b0;
		end else if (last_take) begin
			cnt_q <= '0;
			idx_q <= 1'b0;
		end else if (take) begin
			idx_q <= 1'b1;
		end
	end

	// Result payload, loaded only when the buffer is free.
	always_ff @(posedge clk) begin
		if (load) begin
			pair_q <= pair;
		end
	end

endmodule

@@ design/base64url_unpadded_encoder.sv @@
// Unpadded base64url encoder, one message byte per input item.
// Input channel: in_valid, in_stall, in_item (data_byte, final_byte).
// Output channel: out_valid, out_stall, out_item (out_char, last_char,
// empty_message); one character per output item.
// Configuration: cfg_valid, cfg_ready, cfg_data writes trim_leading_zeros;
// cfg_ready is always high. Write it only while the block is idle.
// The first character of a byte passes the input stage and then the result
// register before it is offered; without a stall, it is taken at the
// following clock edge. Without a stall, a byte yielding one character (or
// none) is taken every cycle; a byte yielding two characters holds the
// single-character output port until both are taken, while the next byte
// waits in the input stage. A sustained stream without stalls runs at one
// character per cycle; the two-entry output register sets this.
// A receiver stall holds the current character; the input stage then fills
// and the block raises in_stall until the output moves again.
// Reset clears all message state and sets trim_leading_zeros to one; no
// item is pending afterwards.
module base64url_unpadded_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  b64u_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output b64u_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);
	import b64u_pkg::*;

	logic      trim_q;
	logic      valid_s1;
	in_item_t  item_s1;
	res_pair_t pair;
	logic      free;
	logic      advance;
	logic      load;
	logic      accept;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			trim_q <= cfg_data;
		end
	end

	// Input stage handshake: an item leaves when its results fit.
	assign advance  = valid_s1 && (free || (pair.count == 2'd0));
	assign load     = advance && (pair.count != 2'd0);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	b64u_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.trim    (trim_q),
		.pair    (pair)
	);

	b64u_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.load      (load),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ design/b64u_checker.sv @@
module b64u_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input b64u_pkg::out_item_t out_item
);
	import b64u_pkg::*;

	// A stalled item holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// An empty marker carries no character and closes the message.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.empty_message |->
			out_item.last_char && (out_item.out_char == CHAR_EMPTY))
		else $error("malformed empty marker");

	// Every other item carries a character of the alphabet.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.empty_message |->
			((out_item.out_char >= CHAR_UPPER_A) && (out_item.out_char <= 7'h5A)) ||
			((out_item.out_char >= CHAR_LOWER_A) && (out_item.out_char <= 7'h7A)) ||
			((out_item.out_char >= CHAR_DIGIT_0) && (out_item.out_char <= 7'h39)) ||
			(out_item.out_char == CHAR_MINUS) || (out_item.out_char == CHAR_ULINE))
		else $error("character outside the base64url alphabet");

	// Nothing is offered straight after reset is released.
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output item offered out of reset");

endmodule

bind base64url_unpadded_encoder b64u_checker u_b64u_checker (.*);

@@ test/tb_top.sv @@
module tb_top;
	import b64u_pkg::*;

	// Marks a stimulus row whose results come from the predictor.
	localparam int USE_PREDICTOR = -1;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP       = 11;
	localparam int LONG_HOLD     = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	// Encoder state as the checker sees it.
	logic        enc_trim;
	logic        enc_leading;
	logic [1:0]  enc_phase;
	logic [3:0]  enc_carry;

	// Characters still owed by the block, oldest first.
	out_item_t   pending_chars [$];

	int          err_count = 0;
	int          cycle_count = 0;
	int          tx_count = 0;
	bit          tx_quiet = 1'b0;

	// One directed stimulus row.
	typedef struct {
		bit         trim;
		logic [7:0] data;
		bit         fin;
		int         typed_n;
		out_item_t  t0;
		out_item_t  t1;
	} dir_row_t;

	dir_row_t    dir_rows [$];

	base64url_unpadded_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	always #1 clk = ~clk;

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Prints one line per mismatch and counts it.
	task automatic report(input string msg);
		$display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	function automatic out_item_t char_item(input logic [6:0] c, input logic l, input logic e);
		return '{out_char: c, last_char: l, empty_message: e};
	endfunction

	// Maps a six-bit group to its character in the URL-safe alphabet.
	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
		if (s < 6'd26) begin
			return CHAR_UPPER_A + 7'(s);
		end else if (s < 6'd52) begin
			return CHAR_LOWER_A + 7'(s - 6'd26);
		end else if (s < 6'd62) begin
			return CHAR_DIGIT_0 + 7'(s - 6'd52);
		end else if (s == 6'd62) begin
			return CHAR_MINUS;
		end
		return CHAR_ULINE;
	endfunction

	function automatic void restart_message();
		enc_leading = 1'b1;
		enc_phase = PHASE_0;
		enc_carry = 4'd0;
	endfunction

	// Works out the characters one byte yields and advances the encoder state.
	function automatic int encode_byte(input in_item_t it, output out_item_t r0,
		output out_item_t r1);
		logic [5:0] s0;
		logic [5:0] s1;
		int         n;
		r0 = '0;
		r1 = '0;
		s0 = '0;
		s1 = '0;
		// A leading zero under trim is dropped; a final one marks the message empty.
		if (enc_trim && enc_leading && it.data_byte == 8'h00) begin
			if (it.final_byte) begin
				r0 = char_item(CHAR_EMPTY, 1'b1, 1'b1);
				restart_message();
				return 1;
			end
			return 0;
		end
		enc_leading = 1'b0;
		case (enc_phase)
			PHASE_1: begin
				s0 = {enc_carry[1:0], it.data_byte[7:4]};
				enc_carry = it.data_byte[3:0];
				enc_phase = PHASE_2;
				n = 1;
			end
			PHASE_2: begin
				s0 = {enc_carry, it.data_byte[7:6]};
				s1 = it.data_byte[5:0];
				enc_carry = 4'd0;
				enc_phase = PHASE_0;
				n = 2;
			end
			default: begin
				s0 = it.data_byte[7:2];
				enc_carry = {2'b00, it.data_byte[1:0]};
				enc_phase = PHASE_1;
				n = 1;
			end
		endcase
		r0 = char_item(sextet_to_ascii(s0), 1'b0, 1'b0);
		// The final byte flushes any leftover bits, zero-filled.
		if (it.final_byte) begin
			if (enc_phase == PHASE_1) begin
				s1 = {enc_carry[1:0], 4'b0000};
				n = 2;
			end else if (enc_phase == PHASE_2) begin
				s1 = {enc_carry, 2'b00};
				n = 2;
			end
		end
		if (n == 2) begin
			r1 = char_item(sextet_to_ascii(s1), 1'b0, 1'b0);
		end
		if (it.final_byte) begin
			if (n == 1) begin
				r0.last_char = 1'b1;
			end else begin
				r1.last_char = 1'b1;
			end
			restart_message();
		end
		return n;
	endfunction

	// Offers one byte after a random gap and books what it should yield.
	task automatic send_item(input in_item_t it, input int typed_n, input out_item_t t0,
		input out_item_t t1);
		int        gap;
		int        n;
		out_item_t p0;
		out_item_t p1;
		if (tx_count % 50 == 0) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
		end
		tx_count++;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_item <= in_item_t'(9'($urandom));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!(in_valid && !in_stall));
		n = encode_byte(it, p0, p1);
		if (typed_n != USE_PREDICTOR) begin
			n = typed_n;
			p0 = t0;
			p1 = t1;
		end
		if (n > 0) begin
			pending_chars.push_back(p0);
		end
		if (n > 1) begin
			pending_chars.push_back(p1);
		end
	endtask

	// Stops offering and waits until every owed character has arrived.
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		in_item <= in_item_t'(9'($urandom));
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_trim(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		enc_trim = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input bit trim, input logic [7:0] data, input bit fin,
		input int typed_n, input out_item_t t0, input out_item_t t1);
		dir_row_t r;
		r.trim = trim;
		r.data = data;
		r.fin = fin;
		r.typed_n = typed_n;
		r.t0 = t0;
		r.t1 = t1;
		dir_rows.push_back(r);
	endtask

	// Receiver: random stalls, quiet stretches and two long hold-offs.
	initial begin
		int  w;
		int  rounds;
		bit  quiet;
		rounds = 0;
		quiet = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rounds % 50 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (rounds == 200 || rounds == 1000) begin
				w = LONG_HOLD;
			end else begin
				w = quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
			rounds++;
			if (w > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (w - 1) @(negedge clk);
				@(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Checks each accepted character against the oldest one owed.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected item %h", out_item));
			end else begin
				e = pending_chars.pop_front();
				if (out_item.out_char !== e.out_char) begin
					report($sformatf("out_char %h, want %h", out_item.out_char, e.out_char));
				end
				if (out_item.last_char !== e.last_char) begin
					report($sformatf("last_char %b, want %b", out_item.last_char,
						e.last_char));
				end
				if (out_item.empty_message !== e.empty_message) begin
					report($sformatf("empty_message %b, want %b",
						out_item.empty_message, e.empty_message));
				end
			end
		end
	end

	// Main sequence: reset, directed rows, random messages, drain.
	initial begin
		in_item_t   it;
		int         len;
		int         lead;
		int         kind;
		int         sent;
		int         r;
		logic [7:0] b;

		enc_trim = 1'b1;
		restart_message();

		// Empty message, the top byte, and a trimmed run into a full group.
		add_row(1, 8'h00, 1, 1, char_item(CHAR_EMPTY, 1'b1, 1'b1), '0);
		add_row(1, 8'hFF, 1, 2, char_item(CHAR_ULINE, 1'b0, 1'b0),
			char_item(7'h77, 1'b1, 1'b0));
		add_row(1, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h01, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'hFF, 1, USE_PREDICTOR, '0, '0);
		// Trim off: zero bytes are encoded.
		add_row(0, 8'h00, 1, 2, char_item(CHAR_UPPER_A, 1'b0, 1'b0),
			char_item(CHAR_UPPER_A, 1'b1, 1'b0));
		add_row(0, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(0, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(0, 8'h00, 1, USE_PREDICTOR, '0, '0);
		// Trim switched off after a skipped byte, then on after an encoded one.
		add_row(1, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(0, 8'h00, 1, USE_PREDICTOR, '0, '0);
		add_row(0, 8'h80, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h00, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h00, 1, USE_PREDICTOR, '0, '0);
		// Minus signs, digits, and a zero final byte that is not leading.
		add_row(1, 8'hFB, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'hEF, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'hBE, 1, USE_PREDICTOR, '0, '0);
		add_row(1, 8'hD3, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h4D, 1, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h41, 0, USE_PREDICTOR, '0, '0);
		add_row(1, 8'h00, 1, USE_PREDICTOR, '0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows; a change of trim waits for the block to go idle.
		foreach (dir_rows[k]) begin
			if (dir_rows[k].trim != enc_trim) begin
				settle_block();
				write_trim(dir_rows[k].trim);
			end
			it.data_byte = dir_rows[k].data;
			it.final_byte = dir_rows[k].fin;
			send_item(it, dir_rows[k].typed_n, dir_rows[k].t0, dir_rows[k].t1);
		end

		// Random messages: mostly short, some with leading zeros, some all zero.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 11) == 0) begin
				settle_block();
				write_trim(1'($urandom_range(0, 1)));
			end
			kind = $urandom_range(0, 9);
			len = (kind == 1) ? $urandom_range(1, 16) : $urandom_range(1, 6);
			if (kind == 0) begin
				lead = len;
			end else begin
				lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
			end
			for (int i = 0; i < len; i++) begin
				// Now and then flip trim in the middle of a message.
				if ($urandom_range(0, 63) == 0) begin
					settle_block();
					write_trim(!enc_trim);
				end
				r = $urandom_range(0, 9);
				if (i < lead || r == 0) begin
					b = 8'h00;
				end else if (r == 1) begin
					b = 8'hFF;
				end else begin
					b = 8'($urandom);
				end
				it.data_byte = b;
				it.final_byte = (i == len - 1);
				send_item(it, USE_PREDICTOR, '0, '0);
				sent++;
			end
		end

		settle_block();
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/b64u_pkg.sv
design/b64u_core.sv
design/b64u_outbuf.sv
design/base64url_unpadded_encoder.sv
design/b64u_checker.sv
test/tb_top.sv
